>>> rtl/complex_transpose_scaled_add_top_defines.svh
// Assertion macros for the checker file of this block.
`ifndef COMPLEX_TRANSPOSE_SCALED_ADD_TOP_DEFINES_SVH
`define COMPLEX_TRANSPOSE_SCALED_ADD_TOP_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define CTAS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every clock edge, reset included.
`define CTAS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/ctas_pkg.sv
// Shared constants, codes and types of the complex transpose-scale-add block.
`timescale 1ns / 1ps
package ctas_pkg;

   localparam int MAX_DIM     = 64;
   localparam int PART_WIDTH  = 16;
   // sign plus three integer bits; the rest of a part is fraction
   localparam int INT_BITS    = 4;
   localparam int REG_INDEX_W = 2;

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_ROWS     = 2'd0,
      REG_COLS     = 2'd1,
      REG_ALPHA_RE = 2'd2,
      REG_ALPHA_IM = 2'd3
   } reg_index_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_ACCUM = 1'b1
   } func_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

>>> rtl/ctas_buffer.sv
// Source element buffer: one write port, one registered read port.
`timescale 1ns / 1ps
module ctas_buffer #(
   parameter int DEPTH  = ctas_pkg::MAX_DIM * ctas_pkg::MAX_DIM,
   parameter int DATA_W = 2 * ctas_pkg::PART_WIDTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ctas_ctrl.sv
// Configuration registers and load/output position tracking.
`timescale 1ns / 1ps
module ctas_ctrl #(
   parameter int MAX_DIM    = ctas_pkg::MAX_DIM,
   parameter int PART_WIDTH = ctas_pkg::PART_WIDTH,
   localparam int DIM_W  = $clog2(MAX_DIM + 1),
   localparam int IDX_W  = $clog2(MAX_DIM),
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM),
   localparam int CSR_W  = (PART_WIDTH > DIM_W) ? PART_WIDTH : DIM_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [ctas_pkg::REG_INDEX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]                     csr_wdata,
   input  logic                                 load_fire,
   input  logic                                 accum_fire,
   output logic [ADDR_W-1:0]                    wr_addr,
   output logic [ADDR_W-1:0]                    rd_addr,
   output logic signed [PART_WIDTH-1:0]         alpha_re,
   output logic signed [PART_WIDTH-1:0]         alpha_im,
   output logic                                 last_pos
);

   logic [DIM_W-1:0]             rows_ff, rows_in;
   logic [DIM_W-1:0]             cols_ff, cols_in;
   logic signed [PART_WIDTH-1:0] alpha_re_ff, alpha_re_in;
   logic signed [PART_WIDTH-1:0] alpha_im_ff, alpha_im_in;
   logic [IDX_W-1:0]             load_row_ff, load_row_in;
   logic [IDX_W-1:0]             load_col_ff, load_col_in;
   logic [ADDR_W-1:0]            load_index_ff, load_index_in;
   logic [IDX_W-1:0]             out_row_ff, out_row_in;
   logic [IDX_W-1:0]             out_col_ff, out_col_in;
   logic [ADDR_W-1:0]            read_address_ff, read_address_in;

   logic [DIM_W-1:0] dim_val;
   logic             lrow_end, lcol_end, orow_end, ocol_end;

   // zero acts as one, anything above the limit acts as the limit
   always_comb begin
      if (csr_wdata == '0) begin
         dim_val = DIM_W'(1);
      end else if (csr_wdata > CSR_W'(MAX_DIM)) begin
         dim_val = DIM_W'(MAX_DIM);
      end else begin
         dim_val = csr_wdata[DIM_W-1:0];
      end
   end

   assign lrow_end = (DIM_W'(load_row_ff) + DIM_W'(1)) == rows_ff;
   assign lcol_end = (DIM_W'(load_col_ff) + DIM_W'(1)) == cols_ff;
   assign orow_end = (DIM_W'(out_row_ff) + DIM_W'(1)) == rows_ff;
   assign ocol_end = (DIM_W'(out_col_ff) + DIM_W'(1)) == cols_ff;

   always_comb begin
      rows_in         = rows_ff;
      cols_in         = cols_ff;
      alpha_re_in     = alpha_re_ff;
      alpha_im_in     = alpha_im_ff;
      load_row_in     = load_row_ff;
      load_col_in     = load_col_ff;
      load_index_in   = load_index_ff;
      out_row_in      = out_row_ff;
      out_col_in      = out_col_ff;
      read_address_in = read_address_ff;

      if (csr_write) begin
         case (ctas_pkg::reg_index_type'(csr_index))
            ctas_pkg::REG_ROWS, ctas_pkg::REG_COLS: begin
               if (ctas_pkg::reg_index_type'(csr_index) == ctas_pkg::REG_ROWS) begin
                  rows_in = dim_val;
               end else begin
                  cols_in = dim_val;
               end
               // a new shape restarts both walks
               load_row_in     = '0;
               load_col_in     = '0;
               load_index_in   = '0;
               out_row_in      = '0;
               out_col_in      = '0;
               read_address_in = '0;
            end
            ctas_pkg::REG_ALPHA_RE: alpha_re_in = $signed(csr_wdata[PART_WIDTH-1:0]);
            ctas_pkg::REG_ALPHA_IM: alpha_im_in = $signed(csr_wdata[PART_WIDTH-1:0]);
            default: ;
         endcase
      end else begin
         if (load_fire) begin
            // source order: row index runs fastest
            if (lrow_end) begin
               load_row_in = '0;
               load_col_in = lcol_end ? '0 : load_col_ff + IDX_W'(1);
            end else begin
               load_row_in = load_row_ff + IDX_W'(1);
            end
            load_index_in = (lrow_end && lcol_end) ? '0 : load_index_ff + ADDR_W'(1);
         end
         if (accum_fire) begin
            // output order: column index runs fastest, address steps by rows
            if (ocol_end) begin
               out_col_in      = '0;
               out_row_in      = orow_end ? '0 : out_row_ff + IDX_W'(1);
               read_address_in = orow_end ? '0 : ADDR_W'(out_row_ff) + ADDR_W'(1);
            end else begin
               out_col_in      = out_col_ff + IDX_W'(1);
               read_address_in = read_address_ff + ADDR_W'(rows_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff         <= DIM_W'(1);
         cols_ff         <= DIM_W'(1);
         alpha_re_ff     <= PART_WIDTH'(1) <<< (PART_WIDTH - ctas_pkg::INT_BITS);
         alpha_im_ff     <= '0;
         load_row_ff     <= '0;
         load_col_ff     <= '0;
         load_index_ff   <= '0;
         out_row_ff      <= '0;
         out_col_ff      <= '0;
         read_address_ff <= '0;
      end else begin
         rows_ff         <= rows_in;
         cols_ff         <= cols_in;
         alpha_re_ff     <= alpha_re_in;
         alpha_im_ff     <= alpha_im_in;
         load_row_ff     <= load_row_in;
         load_col_ff     <= load_col_in;
         load_index_ff   <= load_index_in;
         out_row_ff      <= out_row_in;
         out_col_ff      <= out_col_in;
         read_address_ff <= read_address_in;
      end
   end

   assign wr_addr  = load_index_ff;
   assign rd_addr  = read_address_ff;
   assign alpha_re = alpha_re_ff;
   assign alpha_im = alpha_im_ff;
   assign last_pos = orow_end && ocol_end;

endmodule

>>> rtl/ctas_mac.sv
// Complex multiply, round, accumulate and saturate pipeline with output register.
`timescale 1ns / 1ps
module ctas_mac #(
   parameter int PART_WIDTH = ctas_pkg::PART_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctas_pkg::tag_type             issue_tag,
   input  logic signed [PART_WIDTH-1:0]  old_re,
   input  logic signed [PART_WIDTH-1:0]  old_im,
   input  logic signed [PART_WIDTH-1:0]  alpha_re,
   input  logic signed [PART_WIDTH-1:0]  alpha_im,
   input  logic [2*PART_WIDTH-1:0]       src_data,
   input  logic                          rsp_ready,
   output logic                          advance,
   output logic                          rsp_valid,
   output logic signed [PART_WIDTH-1:0]  new_re,
   output logic signed [PART_WIDTH-1:0]  new_im,
   output logic                          sat,
   output logic                          last
);

   localparam int PROD_W = 2 * PART_WIDTH;
   localparam int FRAC   = PART_WIDTH - ctas_pkg::INT_BITS;
   localparam int RND_W  = PROD_W + 2;
   localparam int SH_W   = RND_W - FRAC;
   localparam int SUM_W  = SH_W + 1;
   localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (FRAC - 1);
   localparam logic signed [SUM_W-1:0] P_MAX =
      SUM_W'((64'sd1 <<< (PART_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] P_MIN = -P_MAX - SUM_W'(1);

   ctas_pkg::tag_type s1_tag_ff, s2_tag_ff, out_tag_ff;
   logic signed [PART_WIDTH-1:0] s1_old_re_ff, s1_old_im_ff;
   logic signed [PART_WIDTH-1:0] s2_old_re_ff, s2_old_im_ff;
   logic signed [PROD_W-1:0]     p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PART_WIDTH-1:0] new_re_ff, new_im_ff;
   logic                         sat_ff;

   logic signed [PART_WIDTH-1:0] src_re, src_im;
   logic signed [RND_W-1:0]      rnd_re, rnd_im, shf_re, shf_im;
   logic signed [SUM_W-1:0]      sum_re, sum_im;
   logic                         clip_re, clip_im;
   logic signed [PART_WIDTH-1:0] new_re_in, new_im_in;

   // the whole pipe freezes while a result waits at the output
   assign advance = !out_tag_ff.valid || rsp_ready;

   assign src_re = $signed(src_data[PART_WIDTH-1:0]);
   assign src_im = $signed(src_data[PROD_W-1:PART_WIDTH]);

   always_comb begin
      rnd_re = RND_W'(p_rr_ff) - RND_W'(p_ii_ff) + RND_HALF;
      rnd_im = RND_W'(p_ri_ff) + RND_W'(p_ir_ff) + RND_HALF;
      // arithmetic shift floors, so ties round up
      shf_re = rnd_re >>> FRAC;
      shf_im = rnd_im >>> FRAC;
      sum_re = SUM_W'($signed(shf_re[SH_W-1:0])) + SUM_W'(s2_old_re_ff);
      sum_im = SUM_W'($signed(shf_im[SH_W-1:0])) + SUM_W'(s2_old_im_ff);
      clip_re = (sum_re > P_MAX) || (sum_re < P_MIN);
      clip_im = (sum_im > P_MAX) || (sum_im < P_MIN);
      if (sum_re > P_MAX) begin
         new_re_in = P_MAX[PART_WIDTH-1:0];
      end else if (sum_re < P_MIN) begin
         new_re_in = P_MIN[PART_WIDTH-1:0];
      end else begin
         new_re_in = sum_re[PART_WIDTH-1:0];
      end
      if (sum_im > P_MAX) begin
         new_im_in = P_MAX[PART_WIDTH-1:0];
      end else if (sum_im < P_MIN) begin
         new_im_in = P_MIN[PART_WIDTH-1:0];
      end else begin
         new_im_in = sum_im[PART_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff  <= '0;
         s2_tag_ff  <= '0;
         out_tag_ff <= '0;
      end else if (advance) begin
         s1_tag_ff  <= issue_tag;
         s2_tag_ff  <= s1_tag_ff;
         out_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_old_re_ff <= old_re;
         s1_old_im_ff <= old_im;
         s2_old_re_ff <= s1_old_re_ff;
         s2_old_im_ff <= s1_old_im_ff;
         p_rr_ff      <= alpha_re * src_re;
         p_ii_ff      <= alpha_im * src_im;
         p_ri_ff      <= alpha_re * src_im;
         p_ir_ff      <= alpha_im * src_re;
         new_re_ff    <= new_re_in;
         new_im_ff    <= new_im_in;
         sat_ff       <= clip_re || clip_im;
      end
   end

   assign rsp_valid = out_tag_ff.valid;
   assign last      = out_tag_ff.last;
   assign new_re    = new_re_ff;
   assign new_im    = new_im_ff;
   assign sat       = sat_ff;

endmodule

>>> rtl/complex_transpose_scaled_add_top.sv
// Accumulate path: the buffer is read at the transfer, then the products are registered,
// then the sum and clip are registered into the output register that drives the result.
// One item per cycle sustained unless the output stalls; load transfers write the buffer and return nothing.
// The request side stalls only while a finished result waits for rsp_ready.
// Synchronous reset: rows = cols = 1, alpha = 1.0, all positions at zero.
// The buffer is not cleared; entries are valid once loaded.
`timescale 1ns / 1ps
module complex_transpose_scaled_add_top #(
   parameter int MAX_DIM    = ctas_pkg::MAX_DIM,
   parameter int PART_WIDTH = ctas_pkg::PART_WIDTH,
   localparam int DIM_W = $clog2(MAX_DIM + 1),
   localparam int CSR_W = (PART_WIDTH > DIM_W) ? PART_WIDTH : DIM_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic signed [PART_WIDTH-1:0]      req_src_re,
   input  logic signed [PART_WIDTH-1:0]      req_src_im,
   input  logic signed [PART_WIDTH-1:0]      req_old_re,
   input  logic signed [PART_WIDTH-1:0]      req_old_im,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [PART_WIDTH-1:0]      rsp_new_re,
   output logic signed [PART_WIDTH-1:0]      rsp_new_im,
   output logic                              rsp_sat,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ctas_pkg::REG_INDEX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]                  csr_wdata
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                         req_fire, load_fire, accum_fire, advance;
   logic [ADDR_W-1:0]            wr_addr, rd_addr;
   logic signed [PART_WIDTH-1:0] alpha_re, alpha_im;
   logic                         last_pos;
   logic [2*PART_WIDTH-1:0]      src_data;
   ctas_pkg::tag_type            issue_tag;

   assign csr_ready  = 1'b1;
   assign req_ready  = advance;
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_func == ctas_pkg::FUNC_LOAD);
   assign accum_fire = req_fire && (req_func == ctas_pkg::FUNC_ACCUM);

   assign issue_tag.valid = accum_fire;
   assign issue_tag.last  = last_pos;

   ctas_ctrl #(
      .MAX_DIM    (MAX_DIM),
      .PART_WIDTH (PART_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .load_fire  (load_fire),
      .accum_fire (accum_fire),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .alpha_re   (alpha_re),
      .alpha_im   (alpha_im),
      .last_pos   (last_pos)
   );

   ctas_buffer #(
      .DEPTH  (DEPTH),
      .DATA_W (2 * PART_WIDTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (wr_addr),
      .wr_data ({req_src_im, req_src_re}),
      .rd_en   (accum_fire),
      .rd_addr (rd_addr),
      .rd_data (src_data)
   );

   ctas_mac #(
      .PART_WIDTH (PART_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue_tag (issue_tag),
      .old_re    (req_old_re),
      .old_im    (req_old_im),
      .alpha_re  (alpha_re),
      .alpha_im  (alpha_im),
      .src_data  (src_data),
      .rsp_ready (rsp_ready),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .new_re    (rsp_new_re),
      .new_im    (rsp_new_im),
      .sat       (rsp_sat),
      .last      (rsp_last)
   );

endmodule

>>> rtl/ctas_checker.sv
// Port-level checks of the top level, bound into it.
`timescale 1ns / 1ps
`include "complex_transpose_scaled_add_top_defines.svh"
module ctas_checker #(
   parameter int PART_WIDTH = ctas_pkg::PART_WIDTH
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PART_WIDTH-1:0] rsp_new_re,
   input logic [PART_WIDTH-1:0] rsp_new_im,
   input logic                  rsp_sat,
   input logic                  rsp_last
);

   // the request side backs off only behind a held result
   `CTAS_ASSERT(a_stall_from_output, !req_ready |-> (rsp_valid && !rsp_ready), "request stalled without output backpressure")

   `CTAS_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_new_re) && $stable(rsp_new_im) && $stable(rsp_sat) && $stable(rsp_last)), "stalled result changed or dropped")

   `CTAS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result pending after reset")

endmodule

bind complex_transpose_scaled_add_top ctas_checker #(
   .PART_WIDTH (PART_WIDTH)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_new_re (rsp_new_re),
   .rsp_new_im (rsp_new_im),
   .rsp_sat    (rsp_sat),
   .rsp_last   (rsp_last)
);
